>>> design/pwr_pkg.sv
// Shared types and constants for the pooling window reducer.
package pwr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DIV_W    = 13;
    localparam int ACC_W    = 48;
    localparam int ROOT_W   = ACC_W / 2;
    localparam int ALU_W    = ROOT_W + 3;
    localparam int CNT_W    = $clog2(ACC_W);

    localparam logic [DIV_W-1:0] MAX_WINDOW = 13'd4096;

    localparam logic signed [SAMPLE_W-1:0] Q_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] Q_MAX = 16'sh7FFF;

    localparam logic [1:0] MODE_AVG = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;
    localparam logic [1:0] MODE_L2  = 2'd2;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_CALC,
        ST_PUT
    } top_state_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT
    } unit_state_t;

    typedef struct packed {
        logic start;
        logic use_sqrt;
    } unit_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] value;
    } unit_rsp_t;

endpackage

>>> design/pwr_iter_unit.sv
// Iterative divide and square root sharing one subtract-compare unit.
module pwr_iter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pwr_pkg::unit_req_t             req,
    input  logic [pwr_pkg::ACC_W-1:0]      dividend,
    input  logic [pwr_pkg::DIV_W-1:0]      divisor,
    output pwr_pkg::unit_rsp_t             rsp
);
    import pwr_pkg::*;

    unit_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              sqrt_reg, sqrt_next;
    logic [ACC_W-1:0]  num_reg, num_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [ALU_W-3:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [ALU_W-1:0]  alu_a;
    logic [ALU_W-1:0]  alu_b;
    logic [ALU_W:0]    alu_diff;
    logic              alu_ge;

    always_comb
    begin
        case (state_reg)
            U_DIV:
            begin
                alu_a = ALU_W'({rem_reg, num_reg[ACC_W-1]});
                alu_b = ALU_W'(div_reg);
            end
            U_SQRT:
            begin
                alu_a = {rem_reg, num_reg[ACC_W-1 -: 2]};
                alu_b = ALU_W'({root_reg, 2'b01});
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
        alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
        alu_ge   = ~alu_diff[ALU_W];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        sqrt_next  = sqrt_reg;
        num_next   = num_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    num_next   = dividend;
                    div_next   = divisor;
                    rem_next   = '0;
                    root_next  = '0;
                    sqrt_next  = req.use_sqrt;
                    cnt_next   = CNT_W'(ACC_W - 1);
                    state_next = U_DIV;
                end
            end
            U_DIV:
            begin
                rem_next = alu_ge ? alu_diff[ALU_W-3:0] : alu_a[ALU_W-3:0];
                num_next = {num_reg[ACC_W-2:0], alu_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (sqrt_reg)
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        cnt_next   = CNT_W'(ROOT_W - 1);
                        state_next = U_SQRT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = U_IDLE;
                    end
                end
            end
            U_SQRT:
            begin
                rem_next  = alu_ge ? alu_diff[ALU_W-3:0] : alu_a[ALU_W-3:0];
                root_next = {root_reg[ROOT_W-2:0], alu_ge};
                num_next  = {num_reg[ACC_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        num_reg  <= num_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = sqrt_reg ? ACC_W'(root_reg) : num_reg;

endmodule

>>> design/pooling_window_reducer_top.sv
// Pooling window reducer: max, average and L2 reduction of streamed windows.
// Non-last beat: accepted every cycle and accumulated into the running total register.
// Last beat: max mode skips the divider; average mode runs a 48-step divide,
// L2 mode a 48-step divide plus 24-step root on the shared subtractor.
// Input is not ready from a last beat until its result enters the output register.
// Reset: max mode, running total at -32768, output empty; reset is asynchronous.
module pooling_window_reducer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pool_mode_we,
    input  logic [1:0]  pool_mode_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample [15:0], divisor [28:16], zero [31:29]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // pooled_value [15:0]
);
    import pwr_pkg::*;

    top_state_t               state_reg, state_next;
    logic [1:0]               mode_reg, mode_next;
    logic [ACC_W-1:0]         total_reg, total_next;
    logic                     neg_reg, neg_next;
    logic [SAMPLE_W-1:0]      res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]      out_data_reg, out_data_next;

    logic signed [SAMPLE_W-1:0] sample;
    logic [DIV_W-1:0]         divisor_in;
    logic [DIV_W-1:0]         div_clamped;
    logic [ACC_W-1:0]         sample_ext;
    logic signed [2*SAMPLE_W-1:0] sq;
    logic [ACC_W:0]           sq_sum;
    logic [ACC_W:0]           lin_sum;
    logic [ACC_W-1:0]         acc;
    logic [ACC_W-1:0]         mag;
    logic [ACC_W-1:0]         start_cur;
    logic [ACC_W-1:0]         start_new;
    logic                     in_beat;
    logic [ACC_W-1:0]         q;
    logic [SAMPLE_W-1:0]      calc_res;

    unit_req_t                req;
    unit_rsp_t                rsp;

    assign sample     = signed'(s_axis_tdata[SAMPLE_W-1:0]);
    assign divisor_in = s_axis_tdata[SAMPLE_W +: DIV_W];
    assign sample_ext = ACC_W'(sample);
    assign in_beat    = s_axis_tvalid && s_axis_tready;

    assign start_cur = (mode_reg == MODE_MAX) ? ACC_W'(Q_MIN) : '0;
    assign start_new = (pool_mode_wdata == MODE_MAX) ? ACC_W'(Q_MIN) : '0;

    always_comb
    begin
        sq      = sample * sample;
        sq_sum  = {1'b0, total_reg} + (ACC_W + 1)'(unsigned'(sq));
        lin_sum = {total_reg[ACC_W-1], total_reg} + {sample_ext[ACC_W-1], sample_ext};
        case (mode_reg)
            MODE_MAX:
            begin
                acc = (signed'(sample_ext) > signed'(total_reg)) ? sample_ext : total_reg;
            end
            MODE_L2:
            begin
                acc = sq_sum[ACC_W] ? {ACC_W{1'b1}} : sq_sum[ACC_W-1:0];
            end
            default:
            begin
                if (lin_sum[ACC_W] != lin_sum[ACC_W-1])
                begin
                    acc = lin_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                         : {1'b0, {(ACC_W-1){1'b1}}};
                end
                else
                begin
                    acc = lin_sum[ACC_W-1:0];
                end
            end
        endcase
        mag = acc[ACC_W-1] ? (~acc + 1'b1) : acc;

        if (divisor_in == '0)
        begin
            div_clamped = DIV_W'(1);
        end
        else if (divisor_in > MAX_WINDOW)
        begin
            div_clamped = MAX_WINDOW;
        end
        else
        begin
            div_clamped = divisor_in;
        end
    end

    assign req.start    = (state_reg == ST_ACC) && in_beat && s_axis_tlast
                          && (mode_reg != MODE_MAX);
    assign req.use_sqrt = (mode_reg == MODE_L2);

    pwr_iter_unit u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .dividend ((mode_reg == MODE_L2) ? acc : mag),
        .divisor  (div_clamped),
        .rsp      (rsp)
    );

    always_comb
    begin
        q = rsp.value;
        if (mode_reg == MODE_L2)
        begin
            calc_res = (q > ACC_W'(Q_MAX)) ? Q_MAX : q[SAMPLE_W-1:0];
        end
        else if (neg_reg)
        begin
            calc_res = (q > ACC_W'(unsigned'(Q_MIN))) ? Q_MIN : (~q[SAMPLE_W-1:0] + 1'b1);
        end
        else
        begin
            calc_res = (q > ACC_W'(Q_MAX)) ? Q_MAX : q[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        total_next     = total_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        s_axis_tready  = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_ACC:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    total_next = acc;
                    if (s_axis_tlast)
                    begin
                        total_next = start_cur;
                        neg_next   = (mode_reg != MODE_L2) && acc[ACC_W-1];
                        if (mode_reg == MODE_MAX)
                        begin
                            res_next   = acc[SAMPLE_W-1:0];
                            state_next = ST_PUT;
                        end
                        else
                        begin
                            state_next = ST_CALC;
                        end
                    end
                end
            end
            ST_CALC:
            begin
                if (rsp.done)
                begin
                    res_next   = calc_res;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase

        if (pool_mode_we)
        begin
            mode_next  = pool_mode_wdata;
            total_next = start_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            mode_reg      <= MODE_MAX;
            total_reg     <= ACC_W'(Q_MIN);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> design/pwr_checker.sv
// Port-level checks for the pooling window reducer, bound to the top level.
module pwr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after a window end");

    a_stream_on: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("input stalled after a mid-window beat");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while accumulating");

endmodule

bind pooling_window_reducer_top pwr_checker u_pwr_checker (.*);
